// ===== design/sba_pkg.sv =====
// ============================================================================
// sba_pkg: shared types and constants of the slab bitmap object allocator
// Holds the payload layouts of the request and response channels, the
// operation and status codes, and the configuration register indexes.
// ============================================================================
package sba_pkg;

    localparam int ADDR_W      = 18;   // pool byte address
    localparam int OBJ_BYTES_W = 12;   // object size register
    localparam int OPS_W       = 7;    // objects per slab register
    localparam int LIVE_W      = 13;   // live object counter
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    // The slab in-use flags are kept in words of at most this many bits.
    localparam int IN_USE_WORD_W = 64;

    localparam logic [OBJ_BYTES_W-1:0] OBJ_BYTES_RESET = 12'd64;
    localparam logic [OPS_W-1:0]       OPS_RESET       = 7'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS_PER_SLAB = 1'd1;

    typedef enum logic
    {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_NO_SLAB  = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef struct packed
    {
        kind_t               kind;
        logic [ADDR_W-1:0]   obj_address;
    } sba_req_t;

    typedef struct packed
    {
        status_t             status;
        logic [ADDR_W-1:0]   result_address;
        logic                slab_released;
        logic [LIVE_W-1:0]   live_objects;
    } sba_rsp_t;

endpackage

// ===== design/sba_if.sv =====
// ============================================================================
// sba_if: valid/ready channels of the slab bitmap object allocator
// One interface for the request channel and one for the response channel.
// A transaction completes on a rising edge with valid and ready both high.
// ============================================================================
interface sba_in_if
    import sba_pkg::*;
();
    logic     valid;
    logic     ready;
    sba_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sba_out_if
    import sba_pkg::*;
();
    logic     valid;
    logic     ready;
    sba_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sba_divider.sv =====
// ============================================================================
// sba_divider: restoring divider, one quotient bit per cycle
// Takes a start pulse with dividend and divisor, produces a done pulse
// once all DIVIDEND_W quotient bits are formed; the quotient holds until the next start.
// ============================================================================
module sba_divider
    import sba_pkg::*;
#(
    parameter int DIVIDEND_W = 12,
    parameter int DIVISOR_W  = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // The partial remainder stays below the divisor, so the trial value
    // with the next dividend bit shifted in needs one extra bit.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/slab_bitmap_object_allocator.sv =====
// ============================================================================
// slab_bitmap_object_allocator: fixed-size object allocator over slabs
// Hands out and takes back objects from a pool of slabs, each with a header
// and an occupancy bitmap, and reports status and the live object count.
// ============================================================================
// Usage. Requests arrive on req (kind, obj_address) and each produces
// exactly one response on rsp (status, result_address, slab_released,
// live_objects). Both channels are valid/ready; a transaction completes on a
// rising clock edge with valid and ready high. The block works on one request
// at a time: req.ready is high only while it is idle.
// An allocate from the current slab reads its bitmap, picks the lowest clear
// slot, sets it and forms the address. An allocate with no current slab
// first scans the in-use words in order and claims the lowest unused slab;
// one whose current slab has no clear slot retires it and does the same.
// For a free, slab and offset are address bits (SLAB_BYTES is a power of
// two), then the one-bit-per-cycle divider turns the offset past the header
// into a slot. A free that fails the slab check answers without the divider.
// The next request is taken the cycle after the response loads. Reset clears
// all slabs to unused, the live count to zero and the registers to 64-byte
// objects and 63 per slab; a slab bitmap is written when its slab is
// claimed, so no clearing pass is needed. A stalled receiver leaves the
// response in the output register; one more request is accepted and its
// response waits until the first one is taken. Configuration is to be
// written on cfg_we only while the block is idle; the block does not
// enforce this.
// ============================================================================
module slab_bitmap_object_allocator
    import sba_pkg::*;
#(
    parameter int NUM_SLABS      = 64,
    parameter int SLAB_BYTES     = 4096,
    parameter int HEADER_BYTES   = 32,
    parameter int SLOTS_PER_SLAB = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sba_in_if.sink                req,
    sba_out_if.source             rsp
);

    localparam int SLAB_IDX_W = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int SLOT_W     = (SLOTS_PER_SLAB > 1) ? $clog2(SLOTS_PER_SLAB) : 1;
    localparam int WORD_W     = (NUM_SLABS < IN_USE_WORD_W) ? NUM_SLABS : IN_USE_WORD_W;
    localparam int NUM_WORDS  = (NUM_SLABS + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = (WORD_W > 1) ? $clog2(WORD_W) : 1;
    localparam int SLAB_SHIFT = $clog2(SLAB_BYTES);
    localparam int OFF_W      = SLAB_SHIFT;
    localparam int SNUM_W     = ADDR_W - SLAB_SHIFT;
    localparam int PROD_W     = SLOT_W + OBJ_BYTES_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_A_PICK,
        ST_CLAIM,
        ST_A_SET,
        ST_A_ADDR,
        ST_F_SLAB,
        ST_F_SLOT,
        ST_DONE
    } state_t;

    // Lowest clear slot of a bitmap: {found, index}.
    function automatic logic [SLOT_W:0] first_clear(input logic [SLOTS_PER_SLAB-1:0] bits);
        logic [SLOT_W:0] r;
        r = '0;
        for (int i = SLOTS_PER_SLAB - 1; i >= 0; i--)
        begin
            if (!bits[i])
            begin
                r = {1'b1, SLOT_W'(i)};
            end
        end
        return r;
    endfunction

    // Configuration registers.
    logic [OBJ_BYTES_W-1:0] obj_bytes_reg;
    logic [OPS_W-1:0]       ops_reg;

    // Control state.
    state_t                 state_reg;
    logic                   cur_valid_reg;
    logic [SLAB_IDX_W-1:0]  cur_slab_reg;
    logic [LIVE_W-1:0]      live_reg;
    logic [WORD_IDX_W-1:0]  scan_word_reg;
    logic [WORD_W-1:0]      in_use_reg [NUM_WORDS];
    logic                   rsp_valid_reg;

    // Working registers of the current request.
    logic [ADDR_W-1:0]         addr_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOTS_PER_SLAB-1:0] bm_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [SLAB_IDX_W-1:0]     free_slab_reg;
    logic [WORD_W-1:0]         iu_word_reg;
    logic [BIT_W-1:0]          free_bit_reg;
    sba_rsp_t                  res_reg;
    sba_rsp_t                  rsp_data_reg;

    // Slab bitmap memory with a registered read port.
    logic [SLOTS_PER_SLAB-1:0] bm_mem [NUM_SLABS];
    logic [SLOTS_PER_SLAB-1:0] bm_rd_reg;
    logic                      bm_rd_en;
    logic [SLAB_IDX_W-1:0]     bm_rd_addr;
    logic                      bm_we;
    logic [SLAB_IDX_W-1:0]     bm_wr_addr;
    logic [SLOTS_PER_SLAB-1:0] bm_wr_data;

    // Divider for the free path.
    logic                   div_start;
    logic [OFF_W-1:0]       div_dividend;
    logic [OBJ_BYTES_W-1:0] div_divisor;
    logic                   div_done;
    logic [OFF_W-1:0]       div_quo;

    logic                   req_fire;
    logic                   rsp_load;
    logic [OBJ_BYTES_W-1:0] unit_bytes;
    logic [OPS_W-1:0]       slot_limit;

    logic [WORD_IDX_W-1:0]  iu_rd_idx;
    logic [WORD_W-1:0]      iu_word;
    logic                   scan_found;
    logic [BIT_W-1:0]       scan_bit;
    logic [SLAB_IDX_W-1:0]  scan_slab;

    logic [SLOT_W:0]           pick_fc;
    logic [SLOTS_PER_SLAB-1:0] bm_set_new;
    logic [SLOT_W:0]           set_fc;
    logic [OPS_W:0]            set_next_count;
    logic                      retire;
    logic [31:0]               addr_sum;

    logic [SNUM_W-1:0]         addr_slab;
    logic [OFF_W-1:0]          addr_off;
    logic                      q_in_range;
    logic [SLAB_IDX_W-1:0]     q_slab;
    logic [WORD_IDX_W-1:0]     q_word;
    logic [BIT_W-1:0]          q_bit;
    logic                      free_ok;
    logic [OFF_W-1:0]          slot_dividend;
    logic                      slot_ok;
    logic [SLOTS_PER_SLAB-1:0] bm_free_new;
    logic [WORD_IDX_W-1:0]     free_word;
    logic [LIVE_W-1:0]         live_inc;
    logic [LIVE_W-1:0]         live_dec;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // A finished result moves to the output register once it is free.
    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // An object size of zero behaves as one byte. The slot limit is capped
    // at the bitmap width and never drops below one.
    always_comb
    begin
        unit_bytes = (obj_bytes_reg == '0) ? OBJ_BYTES_W'(1) : obj_bytes_reg;
        if (ops_reg > OPS_W'(SLOTS_PER_SLAB))
        begin
            slot_limit = OPS_W'(SLOTS_PER_SLAB);
        end
        else if (ops_reg == '0)
        begin
            slot_limit = OPS_W'(1);
        end
        else
        begin
            slot_limit = ops_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_bytes_reg <= OBJ_BYTES_RESET;
            ops_reg       <= OPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OBJECT_BYTES:     obj_bytes_reg <= cfg_data[OBJ_BYTES_W-1:0];
                CFG_OBJECTS_PER_SLAB: ops_reg       <= cfg_data[OPS_W-1:0];
            endcase
        end
    end

    // Slabs are power-of-two sized, so the slab number and the offset are
    // fields of the address. The divider only turns the offset past the
    // header into a slot number.
    assign addr_slab     = addr_reg[ADDR_W-1:SLAB_SHIFT];
    assign addr_off      = addr_reg[SLAB_SHIFT-1:0];
    assign q_in_range    = (int'(addr_slab) < NUM_SLABS);
    assign q_slab        = SLAB_IDX_W'(addr_slab);
    assign q_word        = WORD_IDX_W'(q_slab >> BIT_W);
    assign q_bit         = q_slab[BIT_W-1:0];
    assign slot_dividend = addr_off - OFF_W'(HEADER_BYTES);

    assign div_start    = (state_reg == ST_F_SLAB) && free_ok;
    assign div_dividend = slot_dividend;
    assign div_divisor  = unit_bytes;

    sba_divider #(
        .DIVIDEND_W (OFF_W),
        .DIVISOR_W  (OBJ_BYTES_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // One read of the in-use words per cycle: the scanned word while
    // claiming, the word of the addressed slab while checking a free.
    assign iu_rd_idx = (state_reg == ST_CLAIM) ? scan_word_reg : q_word;
    assign iu_word   = in_use_reg[iu_rd_idx];

    assign free_ok = q_in_range && iu_word[q_bit]
                     && (addr_off >= OFF_W'(HEADER_BYTES));

    // Lowest unused slab in the scanned word; flags past the last slab of a
    // partial word count as used.
    always_comb
    begin
        scan_found = 1'b0;
        scan_bit   = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!iu_word[b] && ((int'(scan_word_reg) * WORD_W + b) < NUM_SLABS))
            begin
                scan_found = 1'b1;
                scan_bit   = BIT_W'(b);
            end
        end
    end

    assign scan_slab = SLAB_IDX_W'({scan_word_reg, scan_bit});

    // Allocation: set the chosen slot; retire a full slab or one at its limit.
    assign pick_fc        = first_clear(bm_rd_reg);
    assign bm_set_new     = bm_reg | (SLOTS_PER_SLAB'(1) << slot_reg);
    assign set_fc         = first_clear(bm_set_new);
    assign set_next_count = (OPS_W + 1)'(set_fc[SLOT_W-1:0]) + 1'b1;
    assign retire         = !set_fc[SLOT_W] || (set_next_count > {1'b0, slot_limit});
    assign addr_sum       = 32'(cur_slab_reg) * 32'(SLAB_BYTES) + 32'(HEADER_BYTES)
                            + 32'(prod_reg);

    // Free: the slot must exist and be marked live.
    assign slot_ok     = (div_quo < OFF_W'(SLOTS_PER_SLAB))
                         && bm_rd_reg[div_quo[SLOT_W-1:0]];
    assign bm_free_new = bm_rd_reg & ~(SLOTS_PER_SLAB'(1) << div_quo[SLOT_W-1:0]);
    assign free_word   = WORD_IDX_W'(free_slab_reg >> BIT_W);

    // The live counter saturates at both ends.
    assign live_inc = (live_reg == '1) ? live_reg : live_reg + 1'b1;
    assign live_dec = (live_reg == '0) ? live_reg : live_reg - 1'b1;

    // Bitmap memory ports.
    assign bm_rd_en   = (req_fire && (req.payload.kind == KIND_ALLOC) && cur_valid_reg)
                        || ((state_reg == ST_F_SLAB) && free_ok);
    assign bm_rd_addr = (state_reg == ST_IDLE) ? cur_slab_reg : q_slab;
    assign bm_we      = (state_reg == ST_A_SET)
                        || ((state_reg == ST_F_SLOT) && div_done && slot_ok);
    assign bm_wr_addr = (state_reg == ST_A_SET) ? cur_slab_reg : free_slab_reg;
    assign bm_wr_data = (state_reg == ST_A_SET) ? bm_set_new : bm_free_new;

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_wr_addr] <= bm_wr_data;
        end
        if (bm_rd_en)
        begin
            bm_rd_reg <= bm_mem[bm_rd_addr];
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_valid_reg <= 1'b0;
            cur_slab_reg  <= '0;
            live_reg      <= '0;
            scan_word_reg <= '0;
            rsp_valid_reg <= 1'b0;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                in_use_reg[w] <= '0;
            end
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req.payload.kind == KIND_FREE)
                        begin
                            addr_reg  <= req.payload.obj_address;
                            state_reg <= ST_F_SLAB;
                        end
                        else if (cur_valid_reg)
                        begin
                            state_reg <= ST_A_PICK;
                        end
                        else
                        begin
                            scan_word_reg <= '0;
                            state_reg     <= ST_CLAIM;
                        end
                    end
                end

                ST_A_PICK:
                begin
                    // A current slab with no clear slot is retired here and a
                    // new one is claimed for the same request.
                    if (pick_fc[SLOT_W])
                    begin
                        slot_reg  <= pick_fc[SLOT_W-1:0];
                        bm_reg    <= bm_rd_reg;
                        state_reg <= ST_A_SET;
                    end
                    else
                    begin
                        cur_valid_reg <= 1'b0;
                        scan_word_reg <= '0;
                        state_reg     <= ST_CLAIM;
                    end
                end

                ST_CLAIM:
                begin
                    if (scan_found)
                    begin
                        in_use_reg[scan_word_reg] <= iu_word | (WORD_W'(1) << scan_bit);
                        cur_slab_reg  <= scan_slab;
                        cur_valid_reg <= 1'b1;
                        slot_reg      <= '0;
                        bm_reg        <= '0;
                        state_reg     <= ST_A_SET;
                    end
                    else if (scan_word_reg == WORD_IDX_W'(NUM_WORDS - 1))
                    begin
                        res_reg.status         <= STATUS_NO_SLAB;
                        res_reg.result_address <= '0;
                        res_reg.slab_released  <= 1'b0;
                        state_reg              <= ST_DONE;
                    end
                    else
                    begin
                        scan_word_reg <= scan_word_reg + 1'b1;
                    end
                end

                ST_A_SET:
                begin
                    if (retire)
                    begin
                        cur_valid_reg <= 1'b0;
                    end
                    prod_reg  <= PROD_W'(slot_reg) * PROD_W'(unit_bytes);
                    live_reg  <= live_inc;
                    state_reg <= ST_A_ADDR;
                end

                ST_A_ADDR:
                begin
                    res_reg.status         <= STATUS_OK;
                    res_reg.result_address <= addr_sum[ADDR_W-1:0];
                    res_reg.slab_released  <= 1'b0;
                    state_reg              <= ST_DONE;
                end

                ST_F_SLAB:
                begin
                    if (free_ok)
                    begin
                        free_slab_reg <= q_slab;
                        iu_word_reg   <= iu_word;
                        free_bit_reg  <= q_bit;
                        state_reg     <= ST_F_SLOT;
                    end
                    else
                    begin
                        res_reg.status         <= STATUS_BAD_FREE;
                        res_reg.result_address <= '0;
                        res_reg.slab_released  <= 1'b0;
                        state_reg              <= ST_DONE;
                    end
                end

                ST_F_SLOT:
                begin
                    if (div_done)
                    begin
                        res_reg.result_address <= '0;
                        if (slot_ok)
                        begin
                            res_reg.status <= STATUS_OK;
                            if (bm_free_new == '0)
                            begin
                                // Last object gone: the slab returns to the pool.
                                in_use_reg[free_word] <= iu_word_reg
                                                         & ~(WORD_W'(1) << free_bit_reg);
                                res_reg.slab_released <= 1'b1;
                                if (cur_valid_reg && (cur_slab_reg == free_slab_reg))
                                begin
                                    cur_valid_reg <= 1'b0;
                                end
                            end
                            else
                            begin
                                res_reg.slab_released <= 1'b0;
                            end
                            live_reg <= live_dec;
                        end
                        else
                        begin
                            res_reg.status        <= STATUS_BAD_FREE;
                            res_reg.slab_released <= 1'b0;
                        end
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    if (rsp_load)
                    begin
                        rsp_data_reg.status         <= res_reg.status;
                        rsp_data_reg.result_address <= res_reg.result_address;
                        rsp_data_reg.slab_released  <= res_reg.slab_released;
                        rsp_data_reg.live_objects   <= live_reg;
                        state_reg                   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/sba_checker.sv =====
// ============================================================================
// sba_checker: port-level checks of the slab bitmap object allocator
// Watches the request and response channels and is bound to the top level.
// ============================================================================
module sba_checker
    import sba_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input sba_rsp_t rsp_payload
);

    logic              seen_reg;
    logic [LIVE_W-1:0] last_live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_live_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            seen_reg      <= 1'b1;
            last_live_reg <= rsp_payload.live_objects;
        end
    end

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous one was in progress");

    // A stalled response stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response changed while stalled");

    // A failed request returns no address and releases no slab.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_payload.status != STATUS_OK)
        |-> (rsp_payload.result_address == '0) && !rsp_payload.slab_released)
        else $error("failed request reported an address or a release");

    // A failed request leaves the live count as the previous response gave it.
    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_reg && (rsp_payload.status != STATUS_OK)
        |-> rsp_payload.live_objects == last_live_reg)
        else $error("failed request changed the live object count");

endmodule

bind slab_bitmap_object_allocator sba_checker u_sba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

// ===== test/tb_slab_bitmap_object_allocator.sv =====
// ============================================================================
// tb_slab_bitmap_object_allocator: self-checking bench for the slab allocator
// Sends allocate and free requests under a range of object sizes and slot
// limits, predicts each response in the bench, and checks every response
// transaction field by field in the order the requests were accepted.
// ============================================================================
module tb_slab_bitmap_object_allocator;
    import sba_pkg::*;

    localparam int NUM_SLABS      = 64;
    localparam int SLAB_BYTES     = 4096;
    localparam int HEADER_BYTES   = 32;
    localparam int SLOTS_PER_SLAB = 64;
    localparam int LIVE_LIMIT     = 8191;

    // Run control. The settle time after the last response and the watchdog
    // limit leave plenty of margin over a free, even across the long receiver
    // hold-off.
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 110;
    localparam int NUM_PHASES    = 9;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    sba_in_if  req_ch ();
    sba_out_if rsp_ch ();

    slab_bitmap_object_allocator
    #(
        .NUM_SLABS      (NUM_SLABS),
        .SLAB_BYTES     (SLAB_BYTES),
        .HEADER_BYTES   (HEADER_BYTES),
        .SLOTS_PER_SLAB (SLOTS_PER_SLAB)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Allocator shadow. These mirror the block's registers and pool state
    // and are advanced once per accepted request transaction.
    // ------------------------------------------------------------------------
    logic [OBJ_BYTES_W-1:0] obj_bytes_reg = OBJ_BYTES_RESET;
    logic [OPS_W-1:0]       slot_cap_reg  = OPS_RESET;
    bit                     slab_busy      [NUM_SLABS];
    bit [63:0]              slab_occupancy [NUM_SLABS];
    bit                     partial_valid;
    int                     partial_slab;
    int                     live_total;

    sba_req_t request_backlog [$];
    sba_rsp_t due_responses   [$];
    sba_rsp_t awaited;

    int send_gap_pct  = 29;
    int recv_gap_pct  = 76;
    int errors        = 0;
    int hold_requests = 0;
    int holds_begun   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    function automatic int lowest_free_slot(bit [63:0] bits);
        for (int i = 0; i < SLOTS_PER_SLAB; i++)
        begin
            if (!bits[i])
                return i;
        end
        return -1;
    endfunction

    // Computes the response to one request and updates the shadow state.
    function automatic sba_rsp_t next_response(sba_req_t r);
        sba_rsp_t rsp;
        int       unit_bytes;
        int       limit;
        int       slot;
        int       nxt;
        int       s;
        int       off;
        bit       ok;

        rsp        = '0;
        unit_bytes = (obj_bytes_reg == 0) ? 1 : int'(obj_bytes_reg);
        limit      = (slot_cap_reg > SLOTS_PER_SLAB) ? SLOTS_PER_SLAB : int'(slot_cap_reg);
        if (limit == 0)
            limit = 1;

        if (r.kind == KIND_ALLOC)
        begin
            slot = -1;
            // A current slab with no clear slot retires, and a fresh slab is
            // claimed within the same request.
            if (partial_valid)
            begin
                slot = lowest_free_slot(slab_occupancy[partial_slab]);
                if (slot < 0)
                    partial_valid = 1'b0;
            end
            if (!partial_valid)
            begin
                s = 0;
                while (s < NUM_SLABS && slab_busy[s])
                    s++;
                if (s < NUM_SLABS)
                begin
                    slab_busy[s]      = 1'b1;
                    slab_occupancy[s] = '0;
                    partial_slab      = s;
                    partial_valid     = 1'b1;
                    slot              = 0;
                end
            end
            if (!partial_valid)
            begin
                rsp.status = STATUS_NO_SLAB;
            end
            else
            begin
                slab_occupancy[partial_slab][slot] = 1'b1;
                // Objects past the slab end are not checked; the address
                // simply wraps to the pool address width.
                rsp.result_address = ADDR_W'(partial_slab * SLAB_BYTES + HEADER_BYTES
                                             + slot * unit_bytes);
                nxt = lowest_free_slot(slab_occupancy[partial_slab]);
                if (nxt < 0 || nxt + 1 > limit)
                    partial_valid = 1'b0;
                if (live_total < LIVE_LIMIT)
                    live_total++;
            end
        end
        else
        begin
            s   = r.obj_address / SLAB_BYTES;
            off = r.obj_address % SLAB_BYTES;
            ok  = s < NUM_SLABS && slab_busy[s] && off >= HEADER_BYTES;
            if (ok)
            begin
                // A misaligned address inside a live slot frees that slot.
                slot = (off - HEADER_BYTES) / unit_bytes;
                ok   = slot < SLOTS_PER_SLAB && slab_occupancy[s][slot];
            end
            if (!ok)
            begin
                rsp.status = STATUS_BAD_FREE;
            end
            else
            begin
                slab_occupancy[s][slot] = 1'b0;
                if (slab_occupancy[s] == '0)
                begin
                    slab_busy[s]      = 1'b0;
                    rsp.slab_released = 1'b1;
                    if (partial_valid && partial_slab == s)
                        partial_valid = 1'b0;
                end
                if (live_total > 0)
                    live_total--;
            end
        end

        rsp.live_objects = LIVE_W'(live_total);
        return rsp;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: offers queued requests, idling at random. A request
    // stays on the channel until its transaction completes.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= request_backlog.pop_front();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every request transaction and checks every
    // response transaction, both in this one process so that the order of
    // prediction and comparison is fixed. It also drives the response ready,
    // with random idling and, on request, a long hold-off that lets the
    // block fill up and stall its request channel.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                due_responses.push_back(next_response(req_ch.payload));

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    awaited = due_responses.pop_front();
                    check_field("status", awaited.status, rsp_ch.payload.status);
                    check_field("result_address", awaited.result_address,
                                rsp_ch.payload.result_address);
                    check_field("slab_released", awaited.slab_released,
                                rsp_ch.payload.slab_released);
                    check_field("live_objects", awaited.live_objects,
                                rsp_ch.payload.live_objects);
                end
            end

            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else if (holds_begun != hold_requests)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= LONG_HOLD;
                holds_begun  <= holds_begun + 1;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("slab_bitmap_object_allocator verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. The stimulus process works on falling edges, but its
    // configuration writes run on rising edges, and in the directed part its
    // queue updates follow them there and can coincide with the driver and monitor.
    task automatic queue_request(input kind_t k, input logic [ADDR_W-1:0] a);
        sba_req_t item;

        item.kind        = k;
        item.obj_address = a;
        request_backlog.push_back(item);
    endtask

    // Returns once every queued request has been accepted and answered.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_ch.valid || due_responses.size() != 0);
    endtask

    // Writes both registers while the block is idle. The unused upper bits
    // of the slot limit write carry random data, which the block ignores.
    task automatic write_config(input logic [OBJ_BYTES_W-1:0] bytes,
                                input logic [OPS_W-1:0] cap);
        @(posedge clk);
        cfg_we        <= 1'b1;
        cfg_index     <= CFG_OBJECT_BYTES;
        cfg_data      <= CFG_DATA_W'(bytes);
        obj_bytes_reg <= bytes;
        @(posedge clk);
        cfg_index     <= CFG_OBJECTS_PER_SLAB;
        cfg_data      <= {(CFG_DATA_W - OPS_W)'($urandom()), cap};
        slot_cap_reg  <= cap;
        @(posedge clk);
        cfg_we        <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence: a directed part for the corner cases, then randomized
    // phases across object sizes and slot limits.
    // ------------------------------------------------------------------------
    initial
    begin
        int                unit_bytes;
        int                alloc_pct;
        int                batch;
        int                issued;
        int                pick;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] live_addrs [$];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, 64-byte objects: frees of unused slabs, of clear
        // slots and inside the header fail; a misaligned address frees its
        // slot and the emptied current slab goes back to the pool.
        queue_request(KIND_FREE, ADDR_W'(32));
        queue_request(KIND_ALLOC, '1);
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_FREE, ADDR_W'(96));
        queue_request(KIND_FREE, ADDR_W'(96));
        queue_request(KIND_FREE, ADDR_W'(16));
        queue_request(KIND_FREE, ADDR_W'(37));
        queue_request(KIND_FREE, '1);
        queue_request(KIND_ALLOC, ADDR_W'(12345));
        wait_idle();

        // A zero object size acts as one byte. Slot 64 lies past the bitmap.
        write_config('0, OPS_W'(64));
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_FREE, ADDR_W'(HEADER_BYTES + SLOTS_PER_SLAB));
        queue_request(KIND_FREE, ADDR_W'(HEADER_BYTES + 1));
        wait_idle();

        // Lowering the slot limit to the fill of the current slab retires
        // it on the next allocate; a limit of zero acts as one.
        write_config('0, '0);
        queue_request(KIND_ALLOC, '1);
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_ALLOC, '1);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            send_gap_pct = (phase < 3) ? 29 : (phase < 6) ? 76 : 0;
            recv_gap_pct = (phase < 3) ? 76 : (phase < 6) ? 29 : 0;
            case (phase)
                0: write_config(OBJ_BYTES_W'(4064), OPS_W'(1));
                1: write_config(OBJ_BYTES_W'(4064), OPS_W'(64));
                2: write_config(OBJ_BYTES_W'(1), OPS_W'(64));
                3: write_config(OBJ_BYTES_W'(100), OPS_W'(127));
                4: write_config('0, '0);
                5: write_config(OBJ_BYTES_W'(48), OPS_W'(5));
                6: write_config(OBJ_BYTES_W'(64), OPS_W'(63));
                7: write_config(OBJ_BYTES_W'($urandom()), OPS_W'($urandom()));
                default: write_config(OBJ_BYTES_W'(7), OPS_W'(33));
            endcase
            @(negedge clk);

            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                wait_idle();

                // Collect the live objects that can be named under the
                // current object size, so most frees hit a real object.
                unit_bytes = (obj_bytes_reg == 0) ? 1 : int'(obj_bytes_reg);
                live_addrs.delete();
                for (int s = 0; s < NUM_SLABS; s++)
                begin
                    for (int k = 0; k < SLOTS_PER_SLAB; k++)
                    begin
                        if (slab_busy[s] && slab_occupancy[s][k]
                            && HEADER_BYTES + k * unit_bytes < SLAB_BYTES)
                            live_addrs.push_back(ADDR_W'(s * SLAB_BYTES + HEADER_BYTES
                                                         + k * unit_bytes));
                    end
                end

                // Each batch leans toward filling, churning or draining.
                case ($urandom_range(2))
                    0: alloc_pct = 80;
                    1: alloc_pct = 50;
                    default: alloc_pct = 20;
                endcase
                batch = $urandom_range(8, 30);
                repeat (batch)
                begin
                    if ($urandom_range(99) < alloc_pct)
                    begin
                        queue_request(KIND_ALLOC, ADDR_W'($urandom()));
                    end
                    else if (live_addrs.size() > 0 && $urandom_range(99) < 80)
                    begin
                        pick = $urandom_range(live_addrs.size() - 1);
                        addr = live_addrs[pick];
                        live_addrs.delete(pick);
                        if ($urandom_range(3) == 0)
                            addr = addr + ADDR_W'($urandom_range(unit_bytes - 1));
                        queue_request(KIND_FREE, addr);
                    end
                    else
                    begin
                        queue_request(KIND_FREE, ADDR_W'($urandom()));
                    end
                end

                // In phases 0 and 6, hold the receiver off while the first batch is offered.
                if (issued == 0 && (phase == 0 || phase == 6))
                    hold_requests++;
                issued += batch;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (due_responses.size() != 0)
        begin
            $error("%0d expected responses never arrived", due_responses.size());
            errors++;
        end

        if (errors == 0)
            $display("slab_bitmap_object_allocator verification clean");
        else
            $display("slab_bitmap_object_allocator verification failed");
        $finish;
    end

endmodule
